@@ hdl/bqc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad cascade package
// Shared sizes, codes and schedule positions of the Q31 biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

   localparam int MAX_STAGES     = 4;
   localparam int TAPS_PER_STAGE = 5;
   localparam int HIST_PER_STAGE = 4;
   localparam int COEFF_WORDS    = MAX_STAGES * TAPS_PER_STAGE;
   localparam int HIST_WORDS     = MAX_STAGES * HIST_PER_STAGE;

   localparam int CADDR_W = (COEFF_WORDS > 1) ? $clog2(COEFF_WORDS) : 1;
   localparam int HADDR_W = (HIST_WORDS > 1) ? $clog2(HIST_WORDS) : 1;
   localparam int STG_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

   localparam int DATA_W      = 32;
   localparam int ACC_W       = 64;
   localparam int MODE_W      = 2;
   localparam int INDEX_W     = 5;
   localparam int COUNT_W     = 3;
   localparam int SHIFT_W     = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int CYC_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POST_SHIFT  = 1'b1;

   // Positions within the schedule of one stage.
   localparam logic [CYC_W-1:0] CYC_X_DATA   = 3'd1;
   localparam logic [CYC_W-1:0] CYC_ACC_INIT = 3'd2;
   localparam logic [CYC_W-1:0] CYC_ACC_END  = 3'd6;
   localparam logic [CYC_W-1:0] CYC_WR_X1    = 3'd2;
   localparam logic [CYC_W-1:0] CYC_WR_X2    = 3'd3;
   localparam logic [CYC_W-1:0] CYC_Y1_DATA  = 3'd4;
   localparam logic [CYC_W-1:0] CYC_WR_Y2    = 3'd5;
   localparam logic [CYC_W-1:0] CYC_LAST     = 3'd7;

   // History slots within one stage.
   localparam logic [1:0] SLOT_X1 = 2'd0;
   localparam logic [1:0] SLOT_X2 = 2'd1;
   localparam logic [1:0] SLOT_Y1 = 2'd2;
   localparam logic [1:0] SLOT_Y2 = 2'd3;

   typedef enum logic [MODE_W-1:0] {
      MODE_FILTER      = 2'd0,
      MODE_COEFF_WRITE = 2'd1,
      MODE_CLEAR       = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

@@ hdl/bqc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module bqc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ hdl/biquad_cascade_q31.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Q31 biquad cascade
// Direct-form-I biquad cascade of up to four stages on signed Q31 samples.
// ----------------------------------------------------------------------------
// A filter transaction runs each active stage in turn and then moves the
// result to the result register. Each stage sends its five products
// through the single shared 32x32 multiplier, fed one coefficient word per
// cycle from the coefficient memory; each stage also covers the memory
// read, the product register and the write-back of the stage output.
// Coefficient writes and clears do not stall the input. Input is stalled
// while a sample is in work; a finished result waits in the output
// register while the next transaction is taken. Coefficients and history
// reset to zero through per-word valid flags, so no clearing pass is
// needed. Feedback coefficients are stored negated, and the stage result
// is the accumulator shifted left by post_shift+1, top 32 bits kept,
// without saturation.
module biquad_cascade_q31
   import bqc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                   req_frame_last,
   input  logic [INDEX_W-1:0]     req_coeff_index,
   input  logic signed [DATA_W-1:0] req_coeff_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [DATA_W-1:0] rsp_filtered_sample,
   output logic                   rsp_frame_last_out,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] stage_count_ff, stage_count_in;
   logic [SHIFT_W-1:0] post_shift_ff, post_shift_in;

   logic [STG_W-1:0]  stage_ff, stage_in;
   logic [CYC_W-1:0]  cyc_ff, cyc_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic              last_ff, last_in;
   logic [DATA_W-1:0] x1old_ff, x1old_in;
   logic [DATA_W-1:0] y1old_ff, y1old_in;
   logic [ACC_W-1:0]  prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;

   logic [COEFF_WORDS-1:0] coeff_vld_ff, coeff_vld_in;
   logic [HIST_WORDS-1:0]  hist_vld_ff, hist_vld_in;
   logic                   coeff_rd_vld_ff, coeff_rd_vld_in;
   logic                   hist_rd_vld_ff, hist_rd_vld_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               req_accept;
   logic               rsp_load;
   logic [STG_W-1:0]   last_stage;

   logic               coeff_we;
   logic [CADDR_W-1:0] coeff_wr_addr;
   logic [CADDR_W-1:0] coeff_rd_addr;
   logic [DATA_W-1:0]  coeff_q;
   logic               hist_we;
   logic [HADDR_W-1:0] hist_wr_addr;
   logic [DATA_W-1:0]  hist_wr_data;
   logic [HADDR_W-1:0] hist_rd_addr;
   logic [DATA_W-1:0]  hist_q;
   logic [HADDR_W-1:0] hist_base;
   logic [1:0]         hist_rd_slot;

   logic signed [DATA_W-1:0] coeff_eff;
   logic signed [DATA_W-1:0] hist_eff;
   logic signed [DATA_W-1:0] operand;
   logic signed [ACC_W-1:0]  mul;
   logic [SHIFT_W:0]         shamt;
   logic [ACC_W-1:0]         shifted;
   logic [DATA_W-1:0]        y;

   bqc_ram #(
      .WIDTH(DATA_W),
      .DEPTH(COEFF_WORDS)
   ) u_coeff_ram (
      .clock  (clock),
      .wr_en  (coeff_we),
      .wr_addr(coeff_wr_addr),
      .wr_data(req_coeff_value),
      .rd_addr(coeff_rd_addr),
      .rd_data(coeff_q)
   );

   bqc_ram #(
      .WIDTH(DATA_W),
      .DEPTH(HIST_WORDS)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (hist_we),
      .wr_addr(hist_wr_addr),
      .wr_data(hist_wr_data),
      .rd_addr(hist_rd_addr),
      .rd_data(hist_q)
   );

   assign req_stall          = (state_ff != ST_IDLE);
   assign req_accept         = req_valid && !req_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_frame_last_out = rsp_last_ff;

   always_comb begin
      if (stage_count_ff == '0) begin
         last_stage = '0;
      end else if (32'(stage_count_ff) > MAX_STAGES) begin
         last_stage = STG_W'(MAX_STAGES - 1);
      end else begin
         last_stage = STG_W'(stage_count_ff - 3'd1);
      end
   end

   always_comb begin
      coeff_eff = coeff_rd_vld_ff ? coeff_q : '0;
      hist_eff  = hist_rd_vld_ff ? hist_q : '0;
      operand   = (cyc_ff == CYC_X_DATA) ? x_ff : hist_eff;
      mul       = coeff_eff * operand;
      shamt     = {1'b0, post_shift_ff} + (SHIFT_W + 1)'(1);
      shifted   = acc_ff << shamt;
      y         = shifted[ACC_W-1:ACC_W-DATA_W];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_FILTER)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if ((cyc_ff == CYC_LAST) && (stage_ff == last_stage)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory control and output load.
   always_comb begin
      coeff_we      = 1'b0;
      coeff_wr_addr = CADDR_W'(req_coeff_index);
      coeff_rd_addr = CADDR_W'(stage_ff) * CADDR_W'(TAPS_PER_STAGE) + CADDR_W'(cyc_ff);
      hist_base     = HADDR_W'(stage_ff) * HADDR_W'(HIST_PER_STAGE);
      hist_rd_slot  = 2'(cyc_ff - 3'd1);
      hist_rd_addr  = hist_base + HADDR_W'(hist_rd_slot);
      hist_we       = 1'b0;
      hist_wr_addr  = hist_base;
      hist_wr_data  = x_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_COEFF_WRITE)
                && (32'(req_coeff_index) < COEFF_WORDS)) begin
               coeff_we = 1'b1;
            end
         end
         ST_RUN: begin
            case (cyc_ff)
               CYC_WR_X1: begin
                  hist_we      = 1'b1;
                  hist_wr_addr = hist_base + HADDR_W'(SLOT_X1);
                  hist_wr_data = x_ff;
               end
               CYC_WR_X2: begin
                  hist_we      = 1'b1;
                  hist_wr_addr = hist_base + HADDR_W'(SLOT_X2);
                  hist_wr_data = x1old_ff;
               end
               CYC_WR_Y2: begin
                  hist_we      = 1'b1;
                  hist_wr_addr = hist_base + HADDR_W'(SLOT_Y2);
                  hist_wr_data = y1old_ff;
               end
               CYC_LAST: begin
                  hist_we      = 1'b1;
                  hist_wr_addr = hist_base + HADDR_W'(SLOT_Y1);
                  hist_wr_data = y;
               end
               default: begin
                  hist_we = 1'b0;
               end
            endcase
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      stage_count_in = stage_count_ff;
      post_shift_in  = post_shift_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STAGE_COUNT: stage_count_in = csr_write_data[COUNT_W-1:0];
            CSR_POST_SHIFT:  post_shift_in  = csr_write_data[SHIFT_W-1:0];
            default:         stage_count_in = stage_count_ff;
         endcase
      end
   end

   always_comb begin
      coeff_vld_in = coeff_vld_ff;
      hist_vld_in  = hist_vld_ff;
      if (req_accept && (req_mode == MODE_CLEAR)) begin
         coeff_vld_in = '0;
         hist_vld_in  = '0;
      end
      if (coeff_we) begin
         coeff_vld_in[coeff_wr_addr] = 1'b1;
      end
      if (hist_we) begin
         hist_vld_in[hist_wr_addr] = 1'b1;
      end
      coeff_rd_vld_in = coeff_vld_ff[coeff_rd_addr];
      hist_rd_vld_in  = hist_vld_ff[hist_rd_addr];
   end

   always_comb begin
      stage_in = stage_ff;
      cyc_in   = cyc_ff;
      x_in     = x_ff;
      last_in  = last_ff;
      x1old_in = x1old_ff;
      y1old_in = y1old_ff;
      prod_in  = mul;
      acc_in   = acc_ff;
      if (req_accept) begin
         stage_in = '0;
         cyc_in   = '0;
         x_in     = req_sample;
         last_in  = req_frame_last;
      end else if (state_ff == ST_RUN) begin
         cyc_in = cyc_ff + 3'd1;
         if (cyc_ff == CYC_ACC_INIT) begin
            acc_in   = prod_ff;
            x1old_in = hist_eff;
         end else if ((cyc_ff > CYC_ACC_INIT) && (cyc_ff <= CYC_ACC_END)) begin
            acc_in = acc_ff + prod_ff;
         end
         if (cyc_ff == CYC_Y1_DATA) begin
            y1old_in = hist_eff;
         end
         if (cyc_ff == CYC_LAST) begin
            x_in     = y;
            stage_in = stage_ff + STG_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = x_ff;
         rsp_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         stage_count_ff  <= COUNT_W'(1);
         post_shift_ff   <= '0;
         coeff_vld_ff    <= '0;
         hist_vld_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         stage_ff        <= '0;
         cyc_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         stage_count_ff  <= stage_count_in;
         post_shift_ff   <= post_shift_in;
         coeff_vld_ff    <= coeff_vld_in;
         hist_vld_ff     <= hist_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         stage_ff        <= stage_in;
         cyc_ff          <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      coeff_rd_vld_ff <= coeff_rd_vld_in;
      hist_rd_vld_ff  <= hist_rd_vld_in;
      x_ff            <= x_in;
      last_ff         <= last_in;
      x1old_ff        <= x1old_in;
      y1old_ff        <= y1old_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      rsp_sample_ff   <= rsp_sample_in;
      rsp_last_ff     <= rsp_last_in;
   end

endmodule
